### hw/rtl/tpc_pkg.sv
package tpc_pkg;

    // trie shape
    localparam int NODE_COUNT    = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int COUNT_BITS    = 20;

    // fixed field widths
    localparam int LETTER_BITS = 5;
    localparam int PREFIX_BITS = 20;

    // derived widths
    localparam int NODE_BITS      = $clog2(NODE_COUNT);
    localparam int FREE_BITS      = $clog2(NODE_COUNT + 1);
    localparam int ALPHA_IDX_BITS = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int SLOT_BITS      = NODE_BITS + COUNT_BITS;
    localparam int ROW_BITS       = ALPHABET_SIZE * SLOT_BITS;

    localparam logic [COUNT_BITS-1:0]  COUNT_LIMIT = '1;
    localparam logic [PREFIX_BITS-1:0] PREFIX_MAX  = '1;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } walk_state_t;

    typedef struct packed
    {
        logic                 we;
        logic [NODE_BITS-1:0] waddr;
        logic [ROW_BITS-1:0]  wdata;
        logic                 re;
        logic [NODE_BITS-1:0] raddr;
    } ram_req_t;

    typedef struct packed
    {
        logic                   valid;
        logic [PREFIX_BITS-1:0] prefix_count;
        logic                   found;
        logic                   pool_full;
    } result_t;

    // position of a letter's slot inside a node row
    function automatic logic [ALPHA_IDX_BITS-1:0] slot_index(input logic [LETTER_BITS-1:0] ltr);
        return ALPHA_IDX_BITS'(ltr);
    endfunction

    // clamp a node count to the reported field
    function automatic logic [PREFIX_BITS-1:0] report_count(input logic [COUNT_BITS-1:0] cnt);
        logic [COUNT_BITS+PREFIX_BITS-1:0] wide;
        wide = (COUNT_BITS + PREFIX_BITS)'(cnt);
        if (wide > (COUNT_BITS + PREFIX_BITS)'(PREFIX_MAX))
        begin
            return PREFIX_MAX;
        end
        return PREFIX_BITS'(wide);
    endfunction

endpackage

### hw/rtl/tpc_if.sv
interface tpc_letter_if;
    logic                                valid;
    logic                                ready;
    tpc_pkg::op_t                        op;
    logic [tpc_pkg::LETTER_BITS-1:0]     letter;
    logic                                word_end;

    modport source (output valid, output op, output letter, output word_end, input ready);
    modport sink   (input valid, input op, input letter, input word_end, output ready);
endinterface

interface tpc_result_if;
    logic                                valid;
    logic                                ready;
    logic [tpc_pkg::PREFIX_BITS-1:0]     prefix_count;
    logic                                found;
    logic                                pool_full;

    modport source (output valid, output prefix_count, output found, output pool_full,
                    input ready);
    modport sink   (input valid, input prefix_count, input found, input pool_full,
                    output ready);
endinterface

### hw/rtl/trie_prefix_counter.sv
// channel   | modport | payload                              | item
// ----------+---------+--------------------------------------+--------------------------------
// letters   | sink    | op, letter[4:0], word_end            | one letter of a word
// results   | source  | prefix_count[19:0], found, pool_full | one per word, on its last letter
//
// each letter is a read of the current node's row from the node memory,
// then the write-back of the new link and count; the next letter waits for it
// after reset the node memory is cleared one row a cycle, all NODE_COUNT rows
// (4096), and letters.ready stays low until that pass is done
// a word's result sits in an output register; the next letter is taken while
// it waits, and a word end stalls only if the previous result is still unread
module trie_prefix_counter (
    input  logic          clk,
    input  logic          rst_n,
    tpc_letter_if.sink    letters,
    tpc_result_if.source  results
);
    import tpc_pkg::*;

    // one row per node: for every letter a child link and that child's count
    ram_req_t                ram_req;
    logic [ROW_BITS-1:0]     ram_rdata;

    // result handed over by the walker, valid for one cycle
    result_t                 walk_result;
    logic                    out_free;

    // output register
    logic                    out_valid_reg;
    logic [PREFIX_BITS-1:0]  prefix_count_reg;
    logic                    found_reg;
    logic                    pool_full_reg;

    tpc_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    tpc_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .letters   (letters),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .out_free  (out_free),
        .result    (walk_result)
    );

    // slot can take a new result when empty or being drained this cycle
    assign out_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (walk_result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_result.valid)
        begin
            prefix_count_reg <= walk_result.prefix_count;
            found_reg        <= walk_result.found;
            pool_full_reg    <= walk_result.pool_full;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.prefix_count = prefix_count_reg;
    assign results.found        = found_reg;
    assign results.pool_full    = pool_full_reg;

    // a new result never overwrites one that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n) walk_result.valid |-> out_free)
        else $error("trie_prefix_counter: result overwritten");

endmodule

### hw/rtl/tpc_ram.sv
module tpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/tpc_walker.sv
module tpc_walker (
    input  logic                          clk,
    input  logic                          rst_n,
    tpc_letter_if.sink                    letters,
    output tpc_pkg::ram_req_t             ram_req,
    input  logic [tpc_pkg::ROW_BITS-1:0]  ram_rdata,
    input  logic                          out_free,
    output tpc_pkg::result_t              result
);
    import tpc_pkg::*;

    walk_state_t state_reg, state_next;

    logic [NODE_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [NODE_BITS-1:0]   walk_node_reg, walk_node_next;
    logic [FREE_BITS-1:0]   next_free_reg, next_free_next;
    logic                   missed_reg, missed_next;
    logic                   ovf_reg, ovf_next;

    // captured item
    op_t                    op_reg;
    logic [LETTER_BITS-1:0] letter_reg;
    logic                   end_reg;

    logic                      accept;
    logic                      fire;
    logic                      clr_last;
    logic                      bad_letter;
    logic                      pool_empty;
    logic [ALPHA_IDX_BITS-1:0] sel_idx;
    logic [SLOT_BITS-1:0]      slot_old;
    logic [NODE_BITS-1:0]      link_old;
    logic [COUNT_BITS-1:0]     cnt_old;
    logic [NODE_BITS-1:0]      step_node;
    logic [COUNT_BITS-1:0]     step_cnt;
    logic                      step_missed;
    logic                      step_ovf;
    logic                      step_write;
    logic                      step_alloc;
    logic [ROW_BITS-1:0]       row_new;

    assign accept   = letters.valid && letters.ready;
    assign fire     = (state_reg == ST_EXEC) && (!end_reg || out_free);
    assign clr_last = (clr_addr_reg == NODE_BITS'(NODE_COUNT - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // one letter step against the row just read
    always_comb
    begin
        bad_letter = int'(letter_reg) >= ALPHABET_SIZE;
        pool_empty = next_free_reg >= FREE_BITS'(NODE_COUNT);
        sel_idx    = bad_letter ? '0 : slot_index(letter_reg);
        slot_old   = ram_rdata[sel_idx * SLOT_BITS +: SLOT_BITS];
        link_old   = slot_old[SLOT_BITS-1:COUNT_BITS];
        cnt_old    = slot_old[COUNT_BITS-1:0];

        step_node   = walk_node_reg;
        step_cnt    = '0;
        step_missed = missed_reg;
        step_ovf    = ovf_reg;
        step_write  = 1'b0;
        step_alloc  = 1'b0;

        if (!missed_reg)
        begin
            if (bad_letter)
            begin
                step_missed = 1'b1;
            end
            else if (link_old == '0)
            begin
                if (op_reg == OP_QUERY)
                begin
                    step_missed = 1'b1;
                end
                else if (pool_empty)
                begin
                    step_missed = 1'b1;
                    step_ovf    = 1'b1;
                end
                else
                begin
                    step_alloc = 1'b1;
                    step_write = 1'b1;
                    step_node  = NODE_BITS'(next_free_reg);
                    step_cnt   = COUNT_BITS'(1);
                end
            end
            else
            begin
                step_node = link_old;
                step_cnt  = cnt_old;
                if (op_reg == OP_INSERT && cnt_old < COUNT_LIMIT)
                begin
                    step_write = 1'b1;
                    step_cnt   = cnt_old + COUNT_BITS'(1);
                end
            end
        end

        row_new = ram_rdata;
        row_new[sel_idx * SLOT_BITS +: SLOT_BITS] = {step_node, step_cnt};
    end

    // outputs and register updates
    always_comb
    begin
        letters.ready = (state_reg == ST_IDLE);

        ram_req.re    = accept;
        ram_req.raddr = walk_node_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = walk_node_reg;
        ram_req.wdata = row_new;

        clr_addr_next  = clr_addr_reg;
        walk_node_next = walk_node_reg;
        next_free_next = next_free_reg;
        missed_next    = missed_reg;
        ovf_next       = ovf_reg;

        result.valid        = fire && end_reg;
        result.found        = !step_missed;
        result.pool_full    = step_ovf;
        result.prefix_count = step_missed ? '0 : report_count(step_cnt);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_addr_reg;
                ram_req.wdata = '0;
                clr_addr_next = clr_addr_reg + NODE_BITS'(1);
            end
            ST_EXEC:
            begin
                if (fire)
                begin
                    ram_req.we = step_write;
                    if (step_alloc)
                    begin
                        next_free_next = next_free_reg + FREE_BITS'(1);
                    end
                    if (end_reg)
                    begin
                        walk_node_next = '0;
                        missed_next    = 1'b0;
                        ovf_next       = 1'b0;
                    end
                    else
                    begin
                        walk_node_next = step_node;
                        missed_next    = step_missed;
                        ovf_next       = step_ovf;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            walk_node_reg <= '0;
            next_free_reg <= FREE_BITS'(1);
            missed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            walk_node_reg <= walk_node_next;
            next_free_reg <= next_free_next;
            missed_reg    <= missed_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= letters.op;
            letter_reg <= letters.letter;
            end_reg    <= letters.word_end;
        end
    end

    // read and write port never used in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_req.re && ram_req.we))
        else $error("tpc_walker: read and write issued together");

    // the walk always sits on an allocated node
    assert property (@(posedge clk) disable iff (!rst_n) walk_node_reg < NODE_BITS'(next_free_reg)
                     || next_free_reg >= FREE_BITS'(NODE_COUNT))
        else $error("tpc_walker: walk node not yet allocated");

    // a word result returns the walk to the root
    assert property (@(posedge clk) disable iff (!rst_n)
                     result.valid |=> walk_node_reg == '0 && !missed_reg && !ovf_reg)
        else $error("tpc_walker: walk not reset after word end");

    // the allocator only grows by one per step and never past the pool
    assert property (@(posedge clk) disable iff (!rst_n)
                     next_free_reg <= FREE_BITS'(NODE_COUNT)
                     && (next_free_reg == $past(next_free_reg)
                         || next_free_reg == $past(next_free_reg) + FREE_BITS'(1)))
        else $error("tpc_walker: allocator moved unexpectedly");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

// trie_prefix_counter bench
// letters go in from a queue of pending items, word reports are checked
// against a trie kept here in plain arrays
module tb;
    import tpc_pkg::*;

    // no item accepted for this many cycles means the block is stuck; the
    // limit must also cover the clearing pass after reset
    localparam int STALL_LIMIT = 4 * NODE_COUNT + 4000;
    // idle cycles after the last report, to catch anything extra
    localparam int TAIL_CYCLES = 32;
    // letters in the whole run, at least
    localparam int RANDOM_GOAL = 1050;
    localparam int BANK_DEPTH  = 64;

    typedef struct {
        op_t                    op;
        logic [LETTER_BITS-1:0] letter;
        logic                   word_end;
        int                     gap;    // idle cycles before this letter
        bit                     drain;  // wait for every report before sending
    } letter_item_t;

    typedef struct packed {
        logic [PREFIX_BITS-1:0] prefix_count;
        logic                   found;
        logic                   pool_full;
    } word_report_t;

    typedef struct packed {
        logic [3:0]                  len;
        logic [7:0][LETTER_BITS-1:0] ltr;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    tpc_letter_if letters_if ();
    tpc_result_if results_if ();

    trie_prefix_counter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .letters (letters_if),
        .results (results_if)
    );

    // registers behind the block inputs, known from time zero
    logic                   send_valid  = 1'b0;
    op_t                    send_op     = OP_INSERT;
    logic [LETTER_BITS-1:0] send_letter = '0;
    logic                   send_end    = 1'b0;
    logic                   take_ready  = 1'b0;

    assign letters_if.valid    = send_valid;
    assign letters_if.op       = send_op;
    assign letters_if.letter   = send_letter;
    assign letters_if.word_end = send_end;
    assign results_if.ready    = take_ready;

    letter_item_t pending_letters [$];
    word_report_t expected_reports [$];
    word_t        inserted_words [$];

    int letters_queued = 0;
    int letters_taken  = 0;
    int mismatch_count = 0;
    int gap_ceiling    = 14;
    int quiet_letters  = 0;
    int quiet_reports  = 0;
    int send_wait      = 0;
    int report_wait    = 0;
    int stall_cycles   = 0;
    bit hold_next      = 1'b0;

    // --------------------------------------------------------------------
    // trie kept by the bench: links, per node prefix counts, free pointer
    // and the position of the word being walked
    // --------------------------------------------------------------------
    bit [NODE_BITS-1:0]  trie_links [NODE_COUNT*ALPHABET_SIZE];
    bit [COUNT_BITS-1:0] trie_counts [NODE_COUNT];
    int unsigned         free_node     = 1;
    int unsigned         walk_at       = 0;
    bit                  walk_lost     = 1'b0;
    bit                  walk_overflow = 1'b0;

    // advance the walk by one accepted letter; a last letter yields a report
    function automatic void trie_walk(op_t op, logic [LETTER_BITS-1:0] ltr, logic last);
        int unsigned  slot;
        int unsigned  child;
        word_report_t report;
        // once a word has left the trie its remaining letters do nothing
        if (!walk_lost)
        begin
            if (ltr >= ALPHABET_SIZE)
            begin
                walk_lost = 1'b1;
            end
            else
            begin
                slot  = walk_at * ALPHABET_SIZE + ltr;
                child = 32'(trie_links[slot]);
                if (child == 0 && op == OP_QUERY)
                begin
                    walk_lost = 1'b1;
                end
                else if (child == 0 && free_node >= NODE_COUNT)
                begin
                    // pool exhausted: the rest of the word is dropped
                    walk_lost     = 1'b1;
                    walk_overflow = 1'b1;
                end
                else
                begin
                    if (child == 0)
                    begin
                        child = free_node;
                        free_node++;
                        trie_links[slot] = NODE_BITS'(child);
                    end
                    walk_at = child;
                    if (op == OP_INSERT && trie_counts[child] != COUNT_LIMIT)
                    begin
                        trie_counts[child]++;
                    end
                end
            end
        end
        if (last)
        begin
            report.found        = !walk_lost;
            report.pool_full    = walk_overflow;
            report.prefix_count = '0;
            if (!walk_lost)
            begin
                report.prefix_count = (trie_counts[walk_at] > PREFIX_MAX) ?
                                      PREFIX_MAX : PREFIX_BITS'(trie_counts[walk_at]);
            end
            expected_reports = {expected_reports, report};
            walk_at       = 0;
            walk_lost     = 1'b0;
            walk_overflow = 1'b0;
        end
    endfunction

    // --------------------------------------------------------------------
    // stimulus helpers
    // --------------------------------------------------------------------

    // idle cycles before a letter, with occasional back-to-back stretches
    function automatic int letter_gap();
        if (quiet_letters > 0)
        begin
            quiet_letters--;
            return 0;
        end
        if ($urandom_range(0, 47) == 0)
        begin
            quiet_letters = 30;
        end
        return $urandom_range(0, gap_ceiling);
    endfunction

    function automatic void push_letter(op_t op, int ltr, bit last);
        letter_item_t item;
        item.op       = op;
        item.letter   = LETTER_BITS'(ltr);
        item.word_end = last;
        item.gap      = letter_gap();
        item.drain    = hold_next;
        hold_next     = 1'b0;
        pending_letters = {pending_letters, item};
        letters_queued++;
    endfunction

    function automatic word_t random_word(int max_len, int top);
        word_t w;
        w     = '0;
        w.len = 4'($urandom_range(1, max_len));
        for (int i = 0; i < 8; i++)
        begin
            w.ltr[i] = LETTER_BITS'($urandom_range(0, top));
        end
        return w;
    endfunction

    function automatic void push_word(word_t w, op_t op);
        for (int i = 0; i < w.len; i++)
        begin
            push_letter(op, w.ltr[i], i == w.len - 1);
        end
    endfunction

    function automatic void remember_word(word_t w);
        if (inserted_words.size() < BANK_DEPTH)
        begin
            inserted_words = {inserted_words, w};
        end
        else
        begin
            inserted_words[$urandom_range(0, BANK_DEPTH - 1)] = w;
        end
    endfunction

    function automatic word_t bank_word();
        return inserted_words[$urandom_range(0, inserted_words.size() - 1)];
    endfunction

    // mostly well formed words over a narrow alphabet so prefixes are shared
    // and queries hit; the rest are misses, mixed ops, letters outside the
    // alphabet and stray letters that split words
    function automatic void queue_random_words(int goal);
        int    pick;
        int    top;
        word_t w;
        while (letters_queued < goal)
        begin
            pick = $urandom_range(0, 99);
            top  = ($urandom_range(0, 3) == 0) ? ALPHABET_SIZE - 1 : 3;
            if (inserted_words.size() == 0 && pick >= 30 && pick < 58)
            begin
                pick = 0;
            end
            if ($urandom_range(0, 149) == 0)
            begin
                hold_next = 1'b1;
            end
            if (pick < 30)
            begin
                w = random_word(6, top);
                push_word(w, OP_INSERT);
                remember_word(w);
            end
            else if (pick < 40)
            begin
                // same word again, counts along its path go up
                push_word(bank_word(), OP_INSERT);
            end
            else if (pick < 58)
            begin
                // a known word or one of its prefixes
                w     = bank_word();
                w.len = 4'($urandom_range(1, w.len));
                push_word(w, OP_QUERY);
            end
            else if (pick < 72)
            begin
                push_word(random_word(7, top), OP_QUERY);
            end
            else if (pick < 84)
            begin
                // each letter picks its own op
                w = (inserted_words.size() != 0 && $urandom_range(0, 1)) ?
                    bank_word() : random_word(6, top);
                for (int i = 0; i < w.len; i++)
                begin
                    push_letter(op_t'($urandom_range(0, 1)), w.ltr[i], i == w.len - 1);
                end
            end
            else if (pick < 92)
            begin
                // a letter outside the alphabet somewhere in the word
                w = random_word(5, top);
                w.ltr[$urandom_range(0, w.len - 1)] =
                    LETTER_BITS'($urandom_range(ALPHABET_SIZE, 31));
                push_word(w, op_t'($urandom_range(0, 1)));
            end
            else
            begin
                push_letter(op_t'($urandom_range(0, 1)), $urandom_range(0, 31),
                            1'($urandom_range(0, 1)));
            end
        end
    endfunction

    // --------------------------------------------------------------------
    // letter driver: waits the item's gap, holds a drain item until every
    // report is in, and feeds the trie on each accepted letter
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid  <= 1'b0;
            send_op     <= OP_INSERT;
            send_letter <= '0;
            send_end    <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (send_valid && letters_if.ready)
            begin
                trie_walk(send_op, send_letter, send_end);
                letters_taken++;
            end
            if (!send_valid || letters_if.ready)
            begin
                if (pending_letters.size() == 0)
                begin
                    send_valid <= 1'b0;
                end
                else if (send_wait < pending_letters[0].gap)
                begin
                    send_wait++;
                    send_valid <= 1'b0;
                end
                else if (pending_letters[0].drain && expected_reports.size() != 0)
                begin
                    send_valid <= 1'b0;
                end
                else
                begin
                    send_valid  <= 1'b1;
                    send_op     <= pending_letters[0].op;
                    send_letter <= pending_letters[0].letter;
                    send_end    <= pending_letters[0].word_end;
                    void'(pending_letters.pop_front());
                    send_wait = 0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // report monitor: random back-pressure, each report compared with the
    // oldest expected one field by field
    // --------------------------------------------------------------------
    word_report_t want_report;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            report_wait = $urandom_range(0, 14);
        end
        else
        begin
            if (results_if.valid && take_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("unexpected report: count %0d found %0d full %0d",
                                 results_if.prefix_count, results_if.found,
                                 results_if.pool_full);
                    end
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    if (results_if.prefix_count !== want_report.prefix_count ||
                        results_if.found !== want_report.found ||
                        results_if.pool_full !== want_report.pool_full)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch at %0t: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, want_report.prefix_count,
                                     want_report.found, want_report.pool_full,
                                     results_if.prefix_count, results_if.found,
                                     results_if.pool_full);
                        end
                    end
                end
                if (quiet_reports > 0)
                begin
                    quiet_reports--;
                    report_wait = 0;
                end
                else
                begin
                    report_wait = $urandom_range(0, 14);
                    if ($urandom_range(0, 31) == 0)
                    begin
                        quiet_reports = 40;
                    end
                end
            end
            if (report_wait > 0)
            begin
                report_wait--;
                take_ready <= 1'b0;
            end
            else
            begin
                take_ready <= 1'b1;
            end
        end
    end

    // watchdog: ends the run if neither side moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((send_valid && letters_if.ready) || (results_if.valid && take_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL trie_prefix_counter");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // test sequence
    // --------------------------------------------------------------------
    initial
    begin
        // letters 0 = a, 25 = z; 26 and up are outside the alphabet
        // empty trie, so the first query misses
        push_letter(OP_QUERY, 0, 1);
        // "a" then "ab": a reaches 2, ab 1
        push_letter(OP_INSERT, 0, 1);
        push_letter(OP_INSERT, 0, 0);
        push_letter(OP_INSERT, 1, 1);
        push_letter(OP_QUERY, 0, 1);
        push_letter(OP_QUERY, 0, 0);
        push_letter(OP_QUERY, 1, 1);
        // highest letter of the alphabet
        push_letter(OP_INSERT, 25, 1);
        // letters outside the alphabet, insert and query
        push_letter(OP_INSERT, 31, 1);
        push_letter(OP_QUERY, 26, 1);
        // a query that misses only at its last letter
        push_letter(OP_QUERY, 0, 0);
        push_letter(OP_QUERY, 1, 0);
        push_letter(OP_QUERY, 25, 1);
        // hit then miss
        push_letter(OP_QUERY, 25, 0);
        push_letter(OP_QUERY, 0, 1);
        // insert then query in the same word
        push_letter(OP_INSERT, 0, 0);
        push_letter(OP_QUERY, 1, 1);
        // early miss: later letters, even an insert, are dropped;
        // sent only after all earlier reports are back
        hold_next = 1'b1;
        push_letter(OP_QUERY, 31, 0);
        push_letter(OP_INSERT, 30, 0);
        push_letter(OP_QUERY, 0, 1);

        queue_random_words(RANDOM_GOAL);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (letters_taken != letters_queued || expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_reports.size() == 0)
        begin
            $display("PASS trie_prefix_counter");
        end
        else
        begin
            $display("FAIL trie_prefix_counter");
        end
        $finish;
    end

endmodule
